// ===== sv/pcs_pkg.sv =====
// Shared types, codes and constants of the power supply supervisor.
// No dependencies; every other file of the block imports this package.
package pcs_pkg;

    localparam int unsigned ID_W       = 29;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned VOLTS_W    = 23;
    localparam int unsigned AMPS_W     = 20;
    localparam int unsigned MEAS_W     = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 29;

    localparam int unsigned DEF_VOLTS_MV  = 48000;
    localparam int unsigned DEF_AMPS_MA   = 1000;
    localparam int unsigned DEF_RAMP_START = 1000;
    localparam int unsigned DEF_RAMP_STEP  = 500;

    localparam int unsigned PERIOD_MS     = 100;
    localparam int unsigned RAMP_MIN_MA   = 100;
    localparam int unsigned CURRENT_ON_DA = 10;
    localparam int unsigned VOLT_SCALE    = 100;

    localparam logic [7:0] CMD_STATUS   = 8'h01;
    localparam logic [7:0] CMD_POWER    = 8'h02;
    localparam logic [7:0] CMD_QUERY_IN = 8'h31;
    localparam logic [7:0] PWR_ON_CODE  = 8'h55;
    localparam logic [7:0] PWR_OFF_CODE = 8'hAA;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_RX       = 3'd1,
        ACT_SET      = 3'd2,
        ACT_POWER    = 3'd3,
        ACT_QUERY_IN = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDR    = 3'd0,
        CFG_SET_BASE     = 3'd1,
        CFG_QUERY_BASE   = 3'd2,
        CFG_QIN_BASE     = 3'd3,
        CFG_STATUS_BASE  = 3'd4,
        CFG_INREPLY_BASE = 3'd5,
        CFG_RAMP_START   = 3'd6,
        CFG_RAMP_STEP    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         action;
        logic [ID_W-1:0]    rx_id;
        logic [DATA_W-1:0]  rx_data;
        logic [VOLTS_W-1:0] set_volts_mv;
        logic [AMPS_W-1:0]  set_amps_ma;
        logic               power_on;
    } t_in_item;

    typedef struct packed {
        logic               frame_valid;
        logic [ID_W-1:0]    tx_id;
        logic [DATA_W-1:0]  tx_data;
        logic               last;
        logic               output_on;
        logic               soft_starting;
        logic               hw_running;
        logic [MEAS_W-1:0]  current_out_da;
        logic [MEAS_W-1:0]  voltage_out_dv;
        logic [MEAS_W-1:0]  input_voltage_raw;
        logic               power_cmd_ok;
        logic               set_cmd_ok;
    } t_out_item;

    // Frame identifiers with the node address already added, and the ramp start and step.
    typedef struct packed {
        logic [ID_W-1:0]   id_set;
        logic [ID_W-1:0]   id_query;
        logic [ID_W-1:0]   id_query_in;
        logic [ID_W-1:0]   id_status;
        logic [ID_W-1:0]   id_in_reply;
        logic [AMPS_W-1:0] ramp_start;
        logic [AMPS_W-1:0] ramp_step;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [TIME_W-1:0]  last_ramp_ms;
        logic [TIME_W-1:0]  last_query_ms;
        logic [VOLTS_W-1:0] target_volts;
        logic [AMPS_W-1:0]  target_amps;
        logic [AMPS_W-1:0]  ramp_amps;
        logic               is_on;
        logic               ramp_active;
        logic               startup_done;
        logic               hw_run;
        logic               soft_shown;
        logic [MEAS_W-1:0]  meas_current;
        logic [MEAS_W-1:0]  meas_voltage;
        logic [MEAS_W-1:0]  meas_input;
        logic               power_ack;
        logic               set_ack;
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_frame;

    // Set command payload: current in bytes 1 to 3, voltage in bytes 5 to 7.
    function automatic logic [DATA_W-1:0] set_payload(input logic [VOLTS_W-1:0] mv,
                                                      input logic [AMPS_W-1:0] ma);
        set_payload = {8'h00, 4'h0, ma, 9'h000, mv};
    endfunction

endpackage

// ===== sv/pcs_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
// Depends on pcs_pkg for the payload types.
interface pcs_in_if;
    import pcs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pcs_out_if;
    import pcs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pcs_cfg_regs.sv =====
// Configuration registers and the derived frame identifiers.
// Depends on pcs_pkg.
module pcs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output pcs_pkg::t_cfg                       o_cfg
);
    import pcs_pkg::*;

    logic [ADDR_W-1:0] r_addr;
    logic [ID_W-1:0]   r_set_base, r_query_base, r_qin_base, r_status_base, r_inreply_base;
    logic [AMPS_W-1:0] r_ramp_start, r_ramp_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr         <= '0;
            r_set_base     <= '0;
            r_query_base   <= '0;
            r_qin_base     <= '0;
            r_status_base  <= '0;
            r_inreply_base <= '0;
            r_ramp_start   <= AMPS_W'(DEF_RAMP_START);
            r_ramp_step    <= AMPS_W'(DEF_RAMP_STEP);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_ADDR:    r_addr         <= i_cfg_wdata[ADDR_W-1:0];
                CFG_SET_BASE:     r_set_base     <= i_cfg_wdata[ID_W-1:0];
                CFG_QUERY_BASE:   r_query_base   <= i_cfg_wdata[ID_W-1:0];
                CFG_QIN_BASE:     r_qin_base     <= i_cfg_wdata[ID_W-1:0];
                CFG_STATUS_BASE:  r_status_base  <= i_cfg_wdata[ID_W-1:0];
                CFG_INREPLY_BASE: r_inreply_base <= i_cfg_wdata[ID_W-1:0];
                CFG_RAMP_START:   r_ramp_start   <= i_cfg_wdata[AMPS_W-1:0];
                CFG_RAMP_STEP:    r_ramp_step    <= i_cfg_wdata[AMPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Identifiers wrap to 29 bits when base plus address overflows.
    assign o_cfg.id_set      = r_set_base + ID_W'(r_addr);
    assign o_cfg.id_query    = r_query_base + ID_W'(r_addr);
    assign o_cfg.id_query_in = r_qin_base + ID_W'(r_addr);
    assign o_cfg.id_status   = r_status_base + ID_W'(r_addr);
    assign o_cfg.id_in_reply = r_inreply_base + ID_W'(r_addr);
    assign o_cfg.ramp_start  = r_ramp_start;
    assign o_cfg.ramp_step   = r_ramp_step;

endmodule

// ===== sv/pcs_step.sv =====
// Combinational step: next supervisor state and up to two frames for one item.
// Depends on pcs_pkg.
module pcs_step (
    input  pcs_pkg::t_in_item i_item,
    input  pcs_pkg::t_state   i_st,
    input  pcs_pkg::t_cfg     i_cfg,
    output pcs_pkg::t_state   o_nxt,
    output logic [1:0]        o_frm_cnt,
    output pcs_pkg::t_frame   o_frm [2]
);
    import pcs_pkg::*;

    t_state            s;
    t_frame            frm [2];
    logic [1:0]        cnt;
    logic              do_pwr;
    logic              pwr_val;
    logic [7:0]        b0;
    logic [TIME_W-1:0] n_time;
    logic [TIME_W-1:0] d_ramp;
    logic [TIME_W-1:0] d_query;
    logic [AMPS_W:0]   sum;

    always_comb begin
        s       = i_st;
        frm[0]  = '0;
        frm[1]  = '0;
        cnt     = 2'd0;
        do_pwr  = 1'b0;
        pwr_val = 1'b0;
        b0      = i_item.rx_data[63:56];
        n_time  = i_st.time_ms + TIME_W'(1);
        d_ramp  = n_time - i_st.last_ramp_ms;
        d_query = n_time - i_st.last_query_ms;
        sum     = (AMPS_W+1)'(i_st.ramp_amps) + (AMPS_W+1)'(i_cfg.ramp_step);

        case (t_action'(i_item.action))
            ACT_TICK: begin
                s.time_ms = n_time;
                if (s.is_on && s.ramp_active) begin
                    if (s.meas_current > MEAS_W'(CURRENT_ON_DA)) begin
                        if (d_ramp >= TIME_W'(PERIOD_MS)) begin
                            s.last_ramp_ms = n_time;
                            if (sum >= (AMPS_W+1)'(s.target_amps)) begin
                                s.ramp_amps   = s.target_amps;
                                s.ramp_active = 1'b0;
                                s.soft_shown  = 1'b0;
                            end else begin
                                s.ramp_amps = sum[AMPS_W-1:0];
                            end
                            frm[cnt[0]] = '{id: i_cfg.id_set,
                                            data: set_payload(s.target_volts, s.ramp_amps)};
                            cnt = cnt + 2'd1;
                        end
                    end else begin
                        s.last_ramp_ms = n_time;
                    end
                end
                if (d_query >= TIME_W'(PERIOD_MS)) begin
                    frm[cnt[0]] = '{id: i_cfg.id_query, data: {CMD_STATUS, 56'h0}};
                    cnt = cnt + 2'd1;
                    s.last_query_ms = n_time;
                end
            end
            ACT_RX: begin
                if (i_item.rx_id == i_cfg.id_status) begin
                    if (b0 == CMD_STATUS) begin
                        s.meas_current = i_item.rx_data[47:32];
                        s.meas_voltage = i_item.rx_data[31:16];
                        s.hw_run       = !i_item.rx_data[0];
                        if (!s.startup_done) begin
                            if (i_item.rx_data[0]) begin
                                do_pwr  = 1'b1;
                                pwr_val = 1'b1;
                            end else begin
                                // A supply found running is adopted as it is.
                                s.is_on        = 1'b1;
                                s.hw_run       = 1'b1;
                                s.ramp_active  = 1'b0;
                                s.target_volts = VOLTS_W'(s.meas_voltage) * VOLTS_W'(VOLT_SCALE);
                            end
                            s.startup_done = 1'b1;
                        end
                    end else if (b0 == CMD_POWER) begin
                        s.power_ack = i_item.rx_data[55:48] != 8'h00;
                    end else begin
                        s.set_ack = b0 != 8'h00;
                    end
                end else if (i_item.rx_id == i_cfg.id_in_reply) begin
                    if (b0 == CMD_QUERY_IN) begin
                        s.meas_input = i_item.rx_data[47:32];
                    end
                end
            end
            ACT_SET: begin
                s.target_volts = i_item.set_volts_mv;
                s.target_amps  = i_item.set_amps_ma;
                if (s.is_on && !s.ramp_active) begin
                    frm[cnt[0]] = '{id: i_cfg.id_set,
                                    data: set_payload(s.target_volts, s.target_amps)};
                    cnt = cnt + 2'd1;
                end
            end
            ACT_POWER: begin
                do_pwr  = 1'b1;
                pwr_val = i_item.power_on;
            end
            ACT_QUERY_IN: begin
                frm[cnt[0]] = '{id: i_cfg.id_query_in, data: {CMD_QUERY_IN, 56'h0}};
                cnt = cnt + 2'd1;
            end
            default: ;
        endcase

        // A power command is the only frame source in its item, so it always
        // lands in the first slot and a power-on adds the set frame after it.
        if (do_pwr) begin
            frm[0] = '{id: i_cfg.id_set,
                       data: {CMD_POWER, 48'h0, (pwr_val ? PWR_ON_CODE : PWR_OFF_CODE)}};
            cnt = 2'd1;
            s.is_on = pwr_val;
            if (pwr_val) begin
                s.ramp_active = 1'b1;
                s.soft_shown  = 1'b1;
                if (s.target_amps <= AMPS_W'(RAMP_MIN_MA)) begin
                    s.ramp_amps = '0;
                end else if (s.target_amps > i_cfg.ramp_start) begin
                    s.ramp_amps = i_cfg.ramp_start;
                end else begin
                    s.ramp_amps = s.target_amps;
                end
                s.last_ramp_ms = s.time_ms;
                frm[1] = '{id: i_cfg.id_set, data: set_payload(s.target_volts, s.ramp_amps)};
                cnt = 2'd2;
            end else begin
                s.ramp_active = 1'b0;
                s.soft_shown  = 1'b0;
            end
        end
    end

    assign o_nxt     = s;
    assign o_frm_cnt = cnt;
    assign o_frm[0]  = frm[0];
    assign o_frm[1]  = frm[1];

endmodule

// ===== sv/pcs_res_buf.sv =====
// Two-entry result buffer that feeds the output channel one beat at a time.
// Depends on pcs_pkg and pcs_out_if.
module pcs_res_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_n,
    input  pcs_pkg::t_out_item   i_res0,
    input  pcs_pkg::t_out_item   i_res1,
    output logic                 o_can_take,
    pcs_out_if.source            o_res
);
    import pcs_pkg::*;

    t_out_item  r_slot [2];
    t_out_item  n_slot [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop        = o_res.valid && o_res.ready;
    assign o_can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_comb begin
        n_slot[0] = r_slot[0];
        n_slot[1] = r_slot[1];
        n_cnt     = r_cnt;
        if (pop) begin
            n_slot[0] = r_slot[1];
            n_cnt     = r_cnt - 2'd1;
        end
        if (i_push_n != 2'd0) begin
            n_slot[n_cnt[0]] = i_res0;
        end
        if (i_push_n == 2'd2) begin
            n_slot[1] = i_res1;
        end
        n_cnt = n_cnt + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
    end

    assign o_res.valid   = r_cnt != 2'd0;
    assign o_res.payload = r_slot[0];

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (i_push_n == 2'd0))
        else $error("push into a full result buffer");

    a_pair_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0 && !r_slot[0].last) |-> (r_cnt == 2'd2))
        else $error("first beat of a pair without its final beat behind it");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push_n == 2'd0) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("result count did not drop after a beat left");
`endif

endmodule

// ===== sv/psu_can_supervisor_soft_start.sv =====
// Flow: an accepted item is registered in the input register and processed when the result
// buffer can take its beats; its result beats are registered in the result buffer, and the
// first leaves when the output is not stalled.
// Throughput: one item per cycle when it yields one beat and the output is not stalled; an item with two
// beats holds the next until its last beat leaves. The single port draining the two-entry buffer sets this.
// Reset: synchronous, active low; state, config and valid/count registers reset at once, data registers do not.
// Top level; depends on pcs_pkg, pcs_if, pcs_cfg_regs, pcs_step and pcs_res_buf.
module psu_can_supervisor_soft_start #(
    parameter int unsigned DEFAULT_VOLTS_MV = pcs_pkg::DEF_VOLTS_MV,
    parameter int unsigned DEFAULT_AMPS_MA  = pcs_pkg::DEF_AMPS_MA
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    pcs_in_if.sink                         i_item,
    pcs_out_if.source                      o_res
);
    import pcs_pkg::*;

    localparam t_state ST_RESET = '{target_volts: VOLTS_W'(DEFAULT_VOLTS_MV),
                                    target_amps:  AMPS_W'(DEFAULT_AMPS_MA),
                                    default:      '0};

    t_cfg       cfg;
    logic       r_in_valid;
    t_in_item   r_in_item;
    t_state     r_st;
    t_state     n_st;
    logic [1:0] frm_cnt;
    t_frame     frm [2];
    logic       can_take;
    logic       fire;
    logic [1:0] push_n;
    t_out_item  res0;
    t_out_item  res1;
    t_out_item  status;

    pcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign fire         = r_in_valid && can_take;
    assign i_item.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_item <= i_item.payload;
        end
    end

    pcs_step u_step (
        .i_item    (r_in_item),
        .i_st      (r_st),
        .i_cfg     (cfg),
        .o_nxt     (n_st),
        .o_frm_cnt (frm_cnt),
        .o_frm     (frm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (fire) begin
            r_st <= n_st;
        end
    end

    // Status fields show the state after the whole item, on every beat of it.
    always_comb begin
        status                   = '0;
        status.output_on         = n_st.is_on;
        status.soft_starting     = n_st.soft_shown;
        status.hw_running        = n_st.hw_run;
        status.current_out_da    = n_st.meas_current;
        status.voltage_out_dv    = n_st.meas_voltage;
        status.input_voltage_raw = n_st.meas_input;
        status.power_cmd_ok      = n_st.power_ack;
        status.set_cmd_ok        = n_st.set_ack;

        res0             = status;
        res0.frame_valid = frm_cnt != 2'd0;
        res0.tx_id       = (frm_cnt != 2'd0) ? frm[0].id : '0;
        res0.tx_data     = (frm_cnt != 2'd0) ? frm[0].data : '0;
        res0.last        = frm_cnt != 2'd2;

        res1             = status;
        res1.frame_valid = 1'b1;
        res1.tx_id       = frm[1].id;
        res1.tx_data     = frm[1].data;
        res1.last        = 1'b1;
    end

    assign push_n = !fire ? 2'd0 : ((frm_cnt == 2'd2) ? 2'd2 : 2'd1);

    pcs_res_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_can_take (can_take),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    a_ramp_needs_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.ramp_active |-> r_st.is_on)
        else $error("current ramp active while output is off");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !can_take) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input item lost while result buffer was full");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_st))
        else $error("supervisor state changed without an item");
`endif

endmodule
